// File: sv/mtmc_pkg.sv
// shared types, codes and constants of the missing-energy plus transverse-mass cut
package mtmc_pkg;

   localparam int MOMENTUM_W = 24;
   localparam int ANGLE_W    = 16;
   localparam int SUM_W      = 26;
   localparam int MODE_W     = 3;
   localparam int CSR_ADDR_W = 1;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   typedef logic [1:0] op_type;
   localparam op_type OP_START    = 2'd0;
   localparam op_type OP_ELECTRON = 2'd1;
   localparam op_type OP_MUON     = 2'd2;
   localparam op_type OP_END      = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NO_LEPTON = 2'd1;
   localparam status_type STATUS_MULTI     = 2'd2;
   localparam status_type STATUS_PRESEL    = 2'd3;

   typedef logic [MODE_W-1:0] mode_type;
   localparam mode_type CMP_LT = 3'd0;
   localparam mode_type CMP_LE = 3'd1;
   localparam mode_type CMP_GT = 3'd2;
   localparam mode_type CMP_GE = 3'd3;
   localparam mode_type CMP_EQ = 3'd4;
   localparam mode_type CMP_NE = 3'd5;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   localparam csr_addr_type REG_SUM_THRESHOLD = 1'd0;
   localparam csr_addr_type REG_COMPARE_MODE  = 1'd1;

   localparam logic [SUM_W-1:0] SUM_MAX = 26'h3FF_FFFF;

   // rotation datapath, angles in units of pi/2^31
   typedef logic signed [33:0] cordic_word_type;
   localparam cordic_word_type CORDIC_GAIN = 34'sd652032874;
   localparam int CORDIC_STEPS = 24;
   localparam int SQRT_STEPS   = 31;

   function automatic logic [31:0] atan_unit(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10679838;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

// File: sv/met_plus_transverse_mass_cut_unit.sv
// missing-energy plus transverse-mass event cut, iterative sine and square root
// start, electron and muon beats are taken in one cycle each, ready again the next cycle
// an end beat with one kept lepton runs a setup step, 31 iterations, a multiply and a finish
//   step (S_PREP, S_ITER, S_MUL, S_FIN); S_FIN waits for a free output, registers the result
// the 31 iterations share one counter; the sine rotation runs in the first 24 of them
// a rejected end beat (not preselected, no lepton or two leptons) goes straight to S_FIN
// synchronous reset clears event state and sets sum_threshold 0, compare_mode greater
module met_plus_transverse_mass_cut_unit
   import mtmc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // momentum[23:0], angle[39:24], preselected[40], selected[41], zero[47:42]
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // op[1:0]
   input  logic [1:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // decision[0], sum_value[26:1], zero[31:27]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // status[1:0]
   output logic [1:0]              rsp_tuser,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [SUM_W-1:0]        csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_ITER = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [SUM_W-1:0]      threshold_ff, threshold_in;
   mode_type              mode_ff, mode_in;
   logic [MOMENTUM_W-1:0] met_mag_ff, met_mag_in;
   logic [ANGLE_W-1:0]    met_az_ff, met_az_in;
   logic                  passes_ff, passes_in;
   logic                  ele_ff, ele_in;
   logic                  muo_ff, muo_in;
   logic [MOMENTUM_W-1:0] lep_mom_ff, lep_mom_in;
   logic [ANGLE_W-1:0]    lep_az_ff, lep_az_in;
   status_type            status_ff, status_in;
   cordic_word_type       x_ff, x_in;
   cordic_word_type       y_ff, y_in;
   cordic_word_type       z_ff, z_in;
   logic [61:0]           sq_n_ff, sq_n_in;
   logic [32:0]           rem_ff, rem_in;
   logic [30:0]           root_ff, root_in;
   logic [61:0]           prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_dec_ff, rsp_dec_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SUM_W-1:0]      rsp_sum_ff, rsp_sum_in;

   op_type                in_op;
   logic [MOMENTUM_W-1:0] in_mom;
   logic [ANGLE_W-1:0]    in_ang;
   logic                  in_pre;
   logic                  in_sel;
   logic                  accept;
   logic                  out_free;

   logic [ANGLE_W-1:0]    diff;
   logic [16:0]           u_fold;
   cordic_word_type       dx, dy, atan_s;
   logic [34:0]           sq_cur, sq_trial;
   logic [30:0]           sine;
   logic [61:0]           rounded;
   logic [SUM_W-1:0]      mt;
   logic [SUM_W:0]        sum_wide;
   logic [SUM_W-1:0]      sum_sat;
   logic                  cmp_hit;

   assign in_op  = req_tuser;
   assign in_mom = req_tdata[23:0];
   assign in_ang = req_tdata[39:24];
   assign in_pre = req_tdata[40];
   assign in_sel = req_tdata[41];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_sum_ff, rsp_dec_ff};
   assign rsp_tuser  = rsp_status_ff;

   // half angle fold and rotation step
   assign diff   = lep_az_ff - met_az_ff;
   assign u_fold = (diff > 16'd32768) ? (17'd65536 - {1'b0, diff}) : {1'b0, diff};
   assign dx     = y_ff >>> cnt_ff;
   assign dy     = x_ff >>> cnt_ff;
   assign atan_s = signed'({2'b00, atan_unit(cnt_ff)});

   // square root digit step
   assign sq_cur   = {rem_ff, sq_n_ff[61:60]};
   assign sq_trial = {2'b00, root_ff, 2'b01};

   // sine clamp to [0, 1.0] in q30
   always_comb begin
      if (y_ff[33]) begin
         sine = 31'd0;
      end else if (y_ff > 34'sd1073741824) begin
         sine = 31'd1073741824;
      end else begin
         sine = y_ff[30:0];
      end
   end

   assign rounded  = prod_ff + 62'h8_0000_0000;
   assign mt       = rounded[61:36];
   assign sum_wide = {3'd0, met_mag_ff} + {1'b0, mt};
   assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

   always_comb begin
      case (mode_ff)
         CMP_LT:  cmp_hit = sum_sat < threshold_ff;
         CMP_LE:  cmp_hit = sum_sat <= threshold_ff;
         CMP_GT:  cmp_hit = sum_sat > threshold_ff;
         CMP_GE:  cmp_hit = sum_sat >= threshold_ff;
         CMP_EQ:  cmp_hit = sum_sat == threshold_ff;
         CMP_NE:  cmp_hit = sum_sat != threshold_ff;
         default: cmp_hit = 1'b0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      threshold_in  = threshold_ff;
      mode_in       = mode_ff;
      met_mag_in    = met_mag_ff;
      met_az_in     = met_az_ff;
      passes_in     = passes_ff;
      ele_in        = ele_ff;
      muo_in        = muo_ff;
      lep_mom_in    = lep_mom_ff;
      lep_az_in     = lep_az_ff;
      status_in     = status_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      sq_n_in       = sq_n_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_dec_in    = rsp_dec_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sum_in    = rsp_sum_ff;

      if (csr_we) begin
         case (csr_addr)
            REG_SUM_THRESHOLD: threshold_in = csr_wdata;
            REG_COMPARE_MODE:  mode_in = csr_wdata[MODE_W-1:0];
            default:           threshold_in = threshold_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (in_op)
                  OP_START: begin
                     met_mag_in = in_mom;
                     met_az_in  = in_ang;
                     passes_in  = in_pre;
                     ele_in     = 1'b0;
                     muo_in     = 1'b0;
                  end
                  OP_ELECTRON: begin
                     if (in_sel && !ele_ff) begin
                        ele_in     = 1'b1;
                        lep_mom_in = in_mom;
                        lep_az_in  = in_ang;
                     end
                  end
                  OP_MUON: begin
                     if (in_sel && !muo_ff) begin
                        muo_in     = 1'b1;
                        lep_mom_in = in_mom;
                        lep_az_in  = in_ang;
                     end
                  end
                  default: begin
                     if (!passes_ff) begin
                        status_in = STATUS_PRESEL;
                        state_in  = S_FIN;
                     end else if (!ele_ff && !muo_ff) begin
                        status_in = STATUS_NO_LEPTON;
                        state_in  = S_FIN;
                     end else if (ele_ff && muo_ff) begin
                        status_in = STATUS_MULTI;
                        state_in  = S_FIN;
                     end else begin
                        status_in = STATUS_OK;
                        state_in  = S_PREP;
                     end
                  end
               endcase
            end
         end
         S_PREP: begin
            sq_n_in  = {48'(lep_mom_ff) * 48'(met_mag_ff), 14'd0};
            x_in     = CORDIC_GAIN;
            y_in     = '0;
            z_in     = signed'({2'b00, u_fold, 15'd0});
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = S_ITER;
         end
         S_ITER: begin
            if (cnt_ff < 5'(CORDIC_STEPS)) begin
               if (!z_ff[33]) begin
                  x_in = x_ff - dx;
                  y_in = y_ff + dy;
                  z_in = z_ff - atan_s;
               end else begin
                  x_in = x_ff + dx;
                  y_in = y_ff - dy;
                  z_in = z_ff + atan_s;
               end
            end
            if (sq_cur >= sq_trial) begin
               rem_in  = 33'(sq_cur - sq_trial);
               root_in = {root_ff[29:0], 1'b1};
            end else begin
               rem_in  = sq_cur[32:0];
               root_in = {root_ff[29:0], 1'b0};
            end
            sq_n_in = {sq_n_ff[59:0], 2'b00};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = root_ff * sine;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (status_ff == STATUS_OK) begin
                  rsp_dec_in = cmp_hit;
                  rsp_sum_in = sum_sat;
               end else begin
                  rsp_dec_in = 1'b0;
                  rsp_sum_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         threshold_ff <= '0;
         mode_ff      <= CMP_GT;
         met_mag_ff   <= '0;
         met_az_ff    <= '0;
         passes_ff    <= 1'b0;
         ele_ff       <= 1'b0;
         muo_ff       <= 1'b0;
         lep_mom_ff   <= '0;
         lep_az_ff    <= '0;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         threshold_ff <= threshold_in;
         mode_ff      <= mode_in;
         met_mag_ff   <= met_mag_in;
         met_az_ff    <= met_az_in;
         passes_ff    <= passes_in;
         ele_ff       <= ele_in;
         muo_ff       <= muo_in;
         lep_mom_ff   <= lep_mom_in;
         lep_az_ff    <= lep_az_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      sq_n_ff       <= sq_n_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      prod_ff       <= prod_in;
      rsp_dec_ff    <= rsp_dec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sum_ff    <= rsp_sum_in;
   end

endmodule

// File: sv/mtmc_checker.sv
// port-level checks of the transverse-mass cut, bound to the top level
module mtmc_checker
   import mtmc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   // a rejected event carries no decision and no sum
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0)
      else $error("rejected event with nonzero payload");

   // the end beat starts the sequencer, so the input closes next cycle
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_END |=> !req_tready)
      else $error("input open right after end beat");

   // no result right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result beat after reset");

endmodule

bind met_plus_transverse_mass_cut_unit mtmc_checker u_mtmc_checker (.*);

// File: sim/met_plus_transverse_mass_cut_unit_tb.sv
// self-checking testbench of the missing-energy plus transverse-mass cut, with its own predictor
module met_plus_transverse_mass_cut_unit_tb;
   import mtmc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam realtime CLOCK_PERIOD = 12ns;
   localparam int RESET_CYCLES = 5;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES = 10;
   localparam int BEATS_PER_PHASE = 150;
   localparam longint GAIN_Q30 = 652032874;
   localparam logic [MOMENTUM_W-1:0] MOMENTUM_MAX = '1;

   typedef struct packed {
      op_type                 op;
      logic [MOMENTUM_W-1:0]  momentum;
      logic [ANGLE_W-1:0]     angle;
      logic                   preselected;
      logic                   selected;
   } beat_type;

   typedef struct packed {
      logic                   decision;
      status_type             status;
      logic [SUM_W-1:0]       sum_value;
   } verdict_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [1:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [SUM_W-1:0]       csr_wdata = '0;

   met_plus_transverse_mass_cut_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // arctangent of 2^-i in units of pi/2^31
   longint arc_step [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   beat_type         beat_backlog [$];
   verdict_type      verdicts_due [$];
   int               beats_queued = 0;
   int               beats_taken = 0;
   int               verdicts_seen = 0;
   int               mismatches = 0;
   int               settings_used = 0;
   int               quiet_cycles = 0;
   bit               quick_phase = 1'b0;
   bit               hold_armed = 1'b0;
   bit               hold_used = 1'b0;

   // event state and cut settings as the block should hold them
   logic [MOMENTUM_W-1:0]  ev_met = '0;
   logic [ANGLE_W-1:0]     ev_met_angle = '0;
   logic                   ev_passes = 1'b0;
   logic                   got_electron = 1'b0;
   logic                   got_muon = 1'b0;
   logic [MOMENTUM_W-1:0]  lep_pt = '0;
   logic [ANGLE_W-1:0]     lep_angle = '0;
   logic [SUM_W-1:0]       cut_threshold = '0;
   mode_type               cut_mode = CMP_GT;

   // sin(u*pi/65536) in q30 by shift-and-add rotation, u in [0,32768]
   function automatic longint half_sine(input logic [16:0] u);
      longint x, y, z, dx, dy;
      x = GAIN_Q30;
      y = 0;
      z = longint'(u) << 15;
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arc_step[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arc_step[i];
         end
      end
      if (y < 0) y = 0;
      if (y > (longint'(1) << 30)) y = longint'(1) << 30;
      return y;
   endfunction

   function automatic longint unsigned int_root(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [SUM_W-1:0] candidate_sum(input logic [MOMENTUM_W-1:0] met,
                                                       input logic [ANGLE_W-1:0] met_angle,
                                                       input logic [MOMENTUM_W-1:0] pt,
                                                       input logic [ANGLE_W-1:0] pt_angle);
      logic [ANGLE_W-1:0] diff;
      logic [16:0] u;
      longint unsigned s, g, mt;
      diff = pt_angle - met_angle;
      u = (diff > 16'd32768) ? 17'd65536 - {1'b0, diff} : {1'b0, diff};
      s = half_sine(u);
      g = int_root((64'(pt) * 64'(met)) << 14);
      mt = (2 * g * s + (64'd1 << 36)) >> 37;
      mt = mt + 64'(met);
      return (mt > 64'(SUM_MAX)) ? SUM_MAX : mt[SUM_W-1:0];
   endfunction

   function automatic logic cut_passes(input logic [SUM_W-1:0] sum);
      case (cut_mode)
         CMP_LT:  return sum < cut_threshold;
         CMP_LE:  return sum <= cut_threshold;
         CMP_GT:  return sum > cut_threshold;
         CMP_GE:  return sum >= cut_threshold;
         CMP_EQ:  return sum == cut_threshold;
         CMP_NE:  return sum != cut_threshold;
         default: return 1'b0;
      endcase
   endfunction

   // update event state for one accepted beat, queue a verdict on an end beat
   function automatic void track_beat(input beat_type b);
      verdict_type v;
      case (b.op)
         OP_START: begin
            ev_met = b.momentum;
            ev_met_angle = b.angle;
            ev_passes = b.preselected;
            got_electron = 1'b0;
            got_muon = 1'b0;
         end
         OP_ELECTRON: begin
            if (b.selected && !got_electron) begin
               got_electron = 1'b1;
               lep_pt = b.momentum;
               lep_angle = b.angle;
            end
         end
         OP_MUON: begin
            if (b.selected && !got_muon) begin
               got_muon = 1'b1;
               lep_pt = b.momentum;
               lep_angle = b.angle;
            end
         end
         default: begin
            v.decision = 1'b0;
            v.sum_value = '0;
            if (!ev_passes) begin
               v.status = STATUS_PRESEL;
            end else if (!got_electron && !got_muon) begin
               v.status = STATUS_NO_LEPTON;
            end else if (got_electron && got_muon) begin
               v.status = STATUS_MULTI;
            end else begin
               v.status = STATUS_OK;
               v.sum_value = candidate_sum(ev_met, ev_met_angle, lep_pt, lep_angle);
               v.decision = cut_passes(v.sum_value);
            end
            verdicts_due.push_back(v);
         end
      endcase
   endfunction

   function automatic int draw_gap();
      if (quick_phase) return 0;
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [MOMENTUM_W-1:0] pick_momentum();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return MOMENTUM_MAX;
         2: return MOMENTUM_W'($urandom_range(0, 1023));
         3: return MOMENTUM_W'($urandom_range(0, 65535));
         default: return MOMENTUM_W'($urandom);
      endcase
   endfunction

   function automatic logic [SUM_W-1:0] pick_threshold();
      case ($urandom_range(0, 3))
         0: return SUM_W'($urandom_range(0, 1 << 20));
         1: return SUM_W'($urandom_range(0, 1 << 24));
         default: return SUM_W'($urandom);
      endcase
   endfunction

   // sender
   beat_type on_bus;
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_beat(on_bus);
            beats_taken++;
            send_gap = draw_gap();
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (beat_backlog.size() != 0) begin
               on_bus = beat_backlog.pop_front();
               req_tdata <= {6'b0, on_bus.selected, on_bus.preselected, on_bus.angle,
                             on_bus.momentum};
               req_tuser <= on_bus.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   verdict_type got, want;
   int rsp_gap = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.decision = rsp_tdata[0];
            got.sum_value = rsp_tdata[SUM_W:1];
            got.status = rsp_tuser;
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
               $error("result beat with nothing pending: decision %0d status %0d sum %0d",
                      got.decision, got.status, got.sum_value);
               mismatches++;
            end else begin
               want = verdicts_due.pop_front();
               if (got.decision !== want.decision) begin
                  $error("decision: expected %0d, got %0d", want.decision, got.decision);
                  mismatches++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  mismatches++;
               end
               if (got.sum_value !== want.sum_value) begin
                  $error("sum_value: expected %0d, got %0d", want.sum_value, got.sum_value);
                  mismatches++;
               end
            end
            rsp_gap = draw_gap();
         end
         if (hold_armed && !hold_used && rsp_tvalid) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_beat(input op_type op, input logic [MOMENTUM_W-1:0] momentum,
                            input logic [ANGLE_W-1:0] angle, input logic preselected,
                            input logic selected);
      beat_type b;
      b.op = op;
      b.momentum = momentum;
      b.angle = angle;
      b.preselected = preselected;
      b.selected = selected;
      beat_backlog.push_back(b);
      beats_queued++;
   endtask

   task automatic apply_settings(input logic [SUM_W-1:0] threshold, input mode_type mode);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= REG_SUM_THRESHOLD;
      csr_wdata <= threshold;
      @(posedge clock);
      csr_addr <= REG_COMPARE_MODE;
      csr_wdata <= SUM_W'(mode);
      @(posedge clock);
      csr_we <= 1'b0;
      cut_threshold = threshold;
      cut_mode = mode;
      settings_used++;
   endtask

   // wait until every queued beat is taken and every verdict has come back
   task automatic settle();
      while (beats_taken != beats_queued) @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly complete events with random content, some stray and broken beats
   task automatic queue_random_run(input int count);
      int first;
      op_type flavor;
      bit mixed;
      first = beats_queued;
      while (beats_queued - first < count) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               repeat ($urandom_range(1, 3))
                  push_beat(op_type'($urandom_range(0, 3)), MOMENTUM_W'($urandom),
                            ANGLE_W'($urandom), 1'($urandom), 1'($urandom));
            end
            2: push_beat(OP_END, MOMENTUM_W'($urandom), ANGLE_W'($urandom), 1'($urandom),
                         1'($urandom));
            default: begin
               flavor = $urandom_range(0, 1) ? OP_MUON : OP_ELECTRON;
               mixed = ($urandom_range(0, 2) == 0);
               push_beat(OP_START, pick_momentum(), ANGLE_W'($urandom),
                         $urandom_range(0, 7) != 0, 1'($urandom));
               repeat ($urandom_range(0, 3))
                  push_beat(mixed ? op_type'($urandom_range(1, 2)) : flavor, pick_momentum(),
                            ANGLE_W'($urandom), 1'($urandom), $urandom_range(0, 3) != 0);
               push_beat(OP_END, MOMENTUM_W'($urandom), ANGLE_W'($urandom), 1'($urandom),
                         1'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      logic [SUM_W-1:0] threshold;
      mode_type mode;
      logic [MOMENTUM_W-1:0] met, pt;
      logic [ANGLE_W-1:0] met_angle, pt_angle;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed events under the reset settings
      push_beat(OP_ELECTRON, 24'hABCDEF, 16'h1234, 1'b0, 1'b1);
      push_beat(OP_END, 24'h0, 16'h0, 1'b0, 1'b0);
      push_beat(OP_END, 24'h0, 16'h0, 1'b0, 1'b0);
      push_beat(OP_START, MOMENTUM_MAX, 16'h0000, 1'b1, 1'b0);
      push_beat(OP_MUON, MOMENTUM_MAX, 16'h8000, 1'b0, 1'b1);
      push_beat(OP_END, MOMENTUM_MAX, 16'hFFFF, 1'b1, 1'b1);
      push_beat(OP_END, 24'h0, 16'h0, 1'b0, 1'b0);
      push_beat(OP_START, 24'h0, 16'h7FFF, 1'b1, 1'b1);
      push_beat(OP_ELECTRON, MOMENTUM_MAX, 16'h0, 1'b1, 1'b0);
      push_beat(OP_END, 24'h0, 16'h0, 1'b0, 1'b0);
      push_beat(OP_ELECTRON, 24'd1000, 16'h8000, 1'b0, 1'b1);
      push_beat(OP_ELECTRON, 24'd5, 16'h0000, 1'b0, 1'b1);
      push_beat(OP_END, 24'h0, 16'h0, 1'b0, 1'b0);
      push_beat(OP_START, 24'd123456, 16'h0000, 1'b1, 1'b0);
      push_beat(OP_MUON, 24'd654321, 16'h8001, 1'b0, 1'b1);
      push_beat(OP_ELECTRON, 24'd1, 16'hFFFF, 1'b0, 1'b1);
      push_beat(OP_END, 24'h0, 16'h0, 1'b0, 1'b0);
      push_beat(OP_START, 24'd1, 16'h0000, 1'b0, 1'b1);
      push_beat(OP_MUON, 24'd77777, 16'h2000, 1'b0, 1'b1);
      push_beat(OP_END, 24'h0, 16'h0, 1'b0, 1'b0);
      push_beat(OP_START, 24'd1, 16'h0001, 1'b1, 1'b0);
      push_beat(OP_ELECTRON, 24'd0, 16'h0001, 1'b0, 1'b1);
      push_beat(OP_END, 24'h0, 16'h0, 1'b0, 1'b0);
      push_beat(OP_START, 24'd500000, 16'h4000, 1'b1, 1'b0);
      push_beat(OP_MUON, 24'd700000, 16'hC000, 1'b0, 1'b1);
      push_beat(OP_END, 24'h0, 16'h0, 1'b0, 1'b0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         mode = (p < 8) ? mode_type'(p) : mode_type'($urandom_range(0, 5));
         case (p)
            0, 8: threshold = SUM_MAX;
            1, 9: threshold = '0;
            default: threshold = pick_threshold();
         endcase
         if (mode == CMP_EQ) begin
            met = pick_momentum();
            pt = pick_momentum();
            met_angle = ANGLE_W'($urandom);
            pt_angle = ANGLE_W'($urandom);
            threshold = candidate_sum(met, met_angle, pt, pt_angle);
         end
         apply_settings(threshold, mode);
         if (mode == CMP_EQ) begin
            push_beat(OP_START, met, met_angle, 1'b1, 1'b0);
            push_beat(OP_ELECTRON, pt, pt_angle, 1'b0, 1'b1);
            push_beat(OP_END, 24'h0, 16'h0, 1'b0, 1'b0);
         end
         quick_phase = (p == 2 || p == 3 || p == 7);
         hold_armed = (p == 3);
         queue_random_run(BEATS_PER_PHASE);
         settle();
         hold_armed = 1'b0;
      end
      quick_phase = 1'b0;

      $display("run covered %0d input beats and %0d result beats over %0d cut settings",
               beats_taken, verdicts_seen, settings_used);
      $display("all compare modes including the two undefined ones, thresholds 0 and max");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
